[rtl/ecc_pkg.sv]
// ---------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants of the elevator car controller: opcodes,
// heading codes, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package ecc_pkg;

	localparam int ECC_FLOORS   = 16;
	localparam int ECC_CAPACITY = 8;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_PAUSE   = 3'd1,
		OP_BOARD   = 3'd2,
		OP_UNLOAD  = 3'd3,
		OP_CHOOSE  = 3'd4,
		OP_REBUILD = 3'd5,
		OP_HALL    = 3'd6,
		OP_NOP     = 3'd7
	} op_t;

	// two's complement heading codes
	localparam logic [1:0] HEAD_IDLE = 2'b00;
	localparam logic [1:0] HEAD_UP   = 2'b01;
	localparam logic [1:0] HEAD_DOWN = 2'b11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH,
		ST_WALK,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic load;        // capture the input beat
		logic exec;        // execute the captured operation
		logic scan;        // process the slot under the counter
		logic cnt_clr;
		logic cnt_inc;
		logic finish;      // settle the heading from the scan flags
		logic emit_status; // plain status result
		logic emit_rider;  // result carrying a leaving rider
	} ecc_cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_last;
		logic cur_leave;
		logic more_leave;
		logic any_leave;
	} ecc_sts_t;

endpackage

[rtl/ecc_ctrl.sv]
// ---------------------------------------------------------------------------
// ecc_ctrl
// Controller state machine: sequences operation execution, slot scans
// and the unload result walk, driving the datapath by commands.
// ---------------------------------------------------------------------------
module ecc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ecc_pkg::ecc_sts_t sts,
	output ecc_pkg::ecc_cmd_t cmd
);
	import ecc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		busy    = 1'b1;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.op) inside
					OP_UNLOAD, OP_CHOOSE, OP_REBUILD: state_d = ST_SCAN;
					default:                          state_d = ST_STATUS;
				endcase
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					case (sts.op)
						OP_UNLOAD: state_d = ST_WALK;
						OP_CHOOSE: state_d = ST_FINISH;
						default:   state_d = ST_STATUS;
					endcase
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_STATUS;
			end
			ST_WALK: begin
				cmd.cnt_inc = 1'b1;
				if (!sts.any_leave) begin
					cmd.emit_status = 1'b1;
					state_d         = ST_IDLE;
				end else if (sts.cur_leave) begin
					cmd.emit_rider = 1'b1;
					if (!sts.more_leave) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_STATUS: begin
				cmd.emit_status = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not make the block busy");

	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_status && cmd.emit_rider))
		else $error("two result kinds emitted at once");

	a_rider_needs_leave: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rider |-> state_q == ST_WALK && sts.any_leave)
		else $error("rider result outside the unload walk");

endmodule

[rtl/ecc_dpath.sv]
// ---------------------------------------------------------------------------
// ecc_dpath
// Datapath: car state, passenger slots, request maps, slot scan counter and
// the registered result beat.
// ---------------------------------------------------------------------------
module ecc_dpath #(
	parameter int FLOORS   = ecc_pkg::ECC_FLOORS,
	parameter int CAPACITY = ecc_pkg::ECC_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ecc_pkg::ecc_cmd_t cmd,
	output ecc_pkg::ecc_sts_t sts,
	input  logic [2:0]        opcode,
	input  logic [3:0]        target_floor,
	input  logic [7:0]        rider_id,
	input  logic [7:0]        pause_cycles,
	input  logic              call_on,
	output logic              result_strobe,
	output logic [3:0]        car_floor_out,
	output logic signed [1:0] heading,
	output logic [7:0]        delay_left,
	output logic [3:0]        riders_aboard,
	output logic              idle_flag,
	output logic              stop_here,
	output logic              requests_ahead,
	output logic              leaving_valid,
	output logic [7:0]        leaving_rider,
	output logic              last,
	output logic              overload
);
	import ecc_pkg::*;

	localparam int FW = $clog2(FLOORS);
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// captured beat
	op_t           op_q;
	logic [FW-1:0] tgt_q;
	logic [7:0]    rid_q;
	logic [7:0]    pause_q;
	logic          call_q;

	// car state
	logic [FW-1:0]       floor_q;
	logic [1:0]          heading_q;
	logic [7:0]          delay_q;
	logic [CW-1:0]       count_q;
	logic [FLOORS-1:0]   cabin_q;
	logic [FLOORS-1:0]   hall_q;
	logic [CAPACITY-1:0] used_q;
	logic [7:0]          rider_q [CAPACITY];
	logic [FW-1:0]       dest_q  [CAPACITY];

	// scan state
	logic [SW-1:0]       idx_q;
	logic [CAPACITY-1:0] leave_q;
	logic                up_q;
	logic                down_q;
	logic                over_q;

	// result beat
	logic              strobe_q;
	logic [3:0]        res_floor_q;
	logic [1:0]        res_heading_q;
	logic [7:0]        res_delay_q;
	logic [3:0]        res_count_q;
	logic              res_idle_q;
	logic              res_stop_q;
	logic              res_ahead_q;
	logic              res_valid_q;
	logic [7:0]        res_rider_q;
	logic              res_last_q;
	logic              res_over_q;

	logic [FW-1:0]       tgt_clamp;
	logic [SW-1:0]       free_idx;
	logic                free_found;
	logic [FLOORS-1:0]   req;
	logic [FLOORS-1:0]   above;
	logic [FLOORS-1:0]   below;
	logic [CAPACITY-1:0] higher;
	logic                ahead_c;
	logic [FW-1:0]       cur_dest;
	logic                cur_match;

	always_comb begin
		if (7'(target_floor) >= 7'(FLOORS)) begin
			tgt_clamp = FW'(FLOORS - 1);
		end else begin
			tgt_clamp = FW'(target_floor);
		end
	end

	// lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!free_found && !used_q[i]) begin
				free_idx   = SW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign req = cabin_q | hall_q;

	always_comb begin
		for (int f = 0; f < FLOORS; f++) begin
			above[f] = FW'(f) > floor_q;
			below[f] = FW'(f) < floor_q;
		end
		for (int j = 0; j < CAPACITY; j++) begin
			higher[j] = SW'(j) > idx_q;
		end
	end

	always_comb begin
		if (heading_q == HEAD_UP) begin
			ahead_c = |(req & above);
		end else if (heading_q == HEAD_DOWN) begin
			ahead_c = |(req & below);
		end else begin
			ahead_c = 1'b0;
		end
	end

	assign cur_dest  = dest_q[idx_q];
	assign cur_match = used_q[idx_q] && (cur_dest == floor_q);

	assign sts.op         = op_q;
	assign sts.cnt_last   = idx_q == SW'(CAPACITY - 1);
	assign sts.cur_leave  = leave_q[idx_q];
	assign sts.more_leave = |(leave_q & higher);
	assign sts.any_leave  = |leave_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			tgt_q   <= tgt_clamp;
			rid_q   <= rider_id;
			pause_q <= pause_cycles;
			call_q  <= call_on;
		end
		if (cmd.exec && op_q == OP_BOARD && count_q < CW'(CAPACITY)) begin
			rider_q[free_idx] <= rid_q;
			dest_q[free_idx]  <= tgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= '0;
			heading_q <= HEAD_IDLE;
			delay_q   <= '0;
			count_q   <= '0;
			cabin_q   <= '0;
			hall_q    <= '0;
			used_q    <= '0;
			idx_q     <= '0;
			leave_q   <= '0;
			up_q      <= 1'b0;
			down_q    <= 1'b0;
			over_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q   <= '0;
				leave_q <= '0;
				up_q    <= 1'b0;
				down_q  <= 1'b0;
				over_q  <= 1'b0;
			end
			if (cmd.exec) begin
				case (op_q)
					OP_TICK: begin
						if (delay_q != '0) begin
							delay_q <= delay_q - 1'b1;
						end else if (heading_q == HEAD_UP) begin
							if (floor_q != FW'(FLOORS - 1)) begin
								floor_q <= floor_q + 1'b1;
							end
						end else if (heading_q == HEAD_DOWN) begin
							if (floor_q != '0) begin
								floor_q <= floor_q - 1'b1;
							end
						end
					end
					OP_PAUSE: delay_q <= pause_q;
					OP_BOARD: begin
						if (count_q >= CW'(CAPACITY)) begin
							over_q <= 1'b1;
						end else begin
							used_q[free_idx] <= 1'b1;
							count_q          <= count_q + 1'b1;
						end
					end
					OP_REBUILD: cabin_q <= '0;
					OP_HALL:    hall_q[tgt_q] <= call_q;
					default: ;
				endcase
			end
			if (cmd.scan && used_q[idx_q]) begin
				case (op_q)
					OP_UNLOAD: begin
						if (cur_match) begin
							used_q[idx_q]  <= 1'b0;
							leave_q[idx_q] <= 1'b1;
							if (count_q != '0) begin
								count_q <= count_q - 1'b1;
							end
						end
					end
					OP_CHOOSE: begin
						if (cur_dest > floor_q) begin
							up_q <= 1'b1;
						end else if (cur_dest < floor_q) begin
							down_q <= 1'b1;
						end
					end
					OP_REBUILD: cabin_q[cur_dest] <= 1'b1;
					default: ;
				endcase
			end
			if (cmd.cnt_clr) begin
				idx_q <= '0;
			end else if (cmd.cnt_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.finish) begin
				case (heading_q)
					HEAD_IDLE: begin
						if (up_q) begin
							heading_q <= HEAD_UP;
						end else if (down_q) begin
							heading_q <= HEAD_DOWN;
						end
					end
					HEAD_UP: heading_q <= up_q ? HEAD_UP : (down_q ? HEAD_DOWN : HEAD_IDLE);
					default: heading_q <= down_q ? HEAD_DOWN : (up_q ? HEAD_UP : HEAD_IDLE);
				endcase
			end
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_status || cmd.emit_rider;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_status || cmd.emit_rider) begin
			res_floor_q   <= 4'(floor_q);
			res_heading_q <= heading_q;
			res_delay_q   <= delay_q;
			res_count_q   <= 4'(count_q);
			res_idle_q    <= ~|req;
			res_stop_q    <= cabin_q[floor_q];
			res_ahead_q   <= ahead_c;
			res_valid_q   <= cmd.emit_rider;
			res_rider_q   <= cmd.emit_rider ? rider_q[idx_q] : 8'd0;
			res_last_q    <= cmd.emit_status || !sts.more_leave;
			res_over_q    <= cmd.emit_status && over_q;
		end
	end

	assign result_strobe  = strobe_q;
	assign car_floor_out  = res_floor_q;
	assign heading        = res_heading_q;
	assign delay_left     = res_delay_q;
	assign riders_aboard  = res_count_q;
	assign idle_flag      = res_idle_q;
	assign stop_here      = res_stop_q;
	assign requests_ahead = res_ahead_q;
	assign leaving_valid  = res_valid_q;
	assign leaving_rider  = res_rider_q;
	assign last           = res_last_q;
	assign overload       = res_over_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(used_q)))
		else $error("rider count disagrees with occupied slots");

	a_leave_free: assert property (@(posedge clk) disable iff (!arst_n)
		(leave_q & used_q) == '0)
		else $error("leaving slot still marked occupied");

	a_floor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(floor_q) < FLOORS)
		else $error("car floor beyond the building");

	a_heading_code: assert property (@(posedge clk) disable iff (!arst_n)
		heading_q == HEAD_IDLE || heading_q == HEAD_UP || heading_q == HEAD_DOWN)
		else $error("heading holds an invalid code");

endmodule

[rtl/elevator_car_controller_unit.sv]
// ---------------------------------------------------------------------------
// elevator_car_controller_unit
// One elevator car: door delay, movement, passenger slots, direction choice
// and cabin/hall request maps, driven by opcoded command beats.
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Tick, pause, board,
// hall call and the unused opcode give one result, and busy drops in the
// same cycle as that result appears, so a new beat can be taken from then
// on. Unload, choose direction and rebuild walk the passenger slots one
// per cycle through the slot storage's single read port; rebuild then
// gives its status result, choose direction first settles the heading,
// and unload walks the slots again up to the last leaving rider,
// emitting one result per leaving rider in slot order on consecutive or
// spaced cycles, or a single status result when nobody leaves. Every
// result appears on result_strobe for exactly one cycle and is not held,
// so the receiver must take it then.
module elevator_car_controller_unit #(
	parameter int FLOORS   = ecc_pkg::ECC_FLOORS,
	parameter int CAPACITY = ecc_pkg::ECC_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        opcode,
	input  logic [3:0]        target_floor,
	input  logic [7:0]        rider_id,
	input  logic [7:0]        pause_cycles,
	input  logic              call_on,
	output logic              result_strobe,
	output logic [3:0]        car_floor_out,
	output logic signed [1:0] heading,
	output logic [7:0]        delay_left,
	output logic [3:0]        riders_aboard,
	output logic              idle_flag,
	output logic              stop_here,
	output logic              requests_ahead,
	output logic              leaving_valid,
	output logic [7:0]        leaving_rider,
	output logic              last,
	output logic              overload
);
	import ecc_pkg::*;

	ecc_cmd_t cmd;
	ecc_sts_t sts;

	ecc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	ecc_dpath #(
		.FLOORS   (FLOORS),
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.target_floor   (target_floor),
		.rider_id       (rider_id),
		.pause_cycles   (pause_cycles),
		.call_on        (call_on),
		.result_strobe  (result_strobe),
		.car_floor_out  (car_floor_out),
		.heading        (heading),
		.delay_left     (delay_left),
		.riders_aboard  (riders_aboard),
		.idle_flag      (idle_flag),
		.stop_here      (stop_here),
		.requests_ahead (requests_ahead),
		.leaving_valid  (leaving_valid),
		.leaving_rider  (leaving_rider),
		.last           (last),
		.overload       (overload)
	);

endmodule

[dv/tb_elevator_car_controller_unit.sv]
// ---------------------------------------------------------------------------
// tb_elevator_car_controller_unit
// Drives opcoded command beats into the car controller and checks every
// status result against an in-bench model of the car: directed checks of
// boarding, overload, unload and motion, then random traffic built from
// boarding trips mixed with noise, under several sender idle patterns.
// ---------------------------------------------------------------------------
module tb_elevator_car_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ecc_pkg::*;

	localparam int FLOORS      = ECC_FLOORS;
	localparam int CAP         = ECC_CAPACITY;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 2 * CAP + 8;

	typedef struct {
		logic [3:0] floor_no;
		logic [1:0] head;
		logic [7:0] delay;
		logic [3:0] riders;
		logic       idle;
		logic       stop;
		logic       ahead;
		logic       lv;
		logic [7:0] lrider;
		logic       lst;
		logic       ovl;
	} car_status_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic [2:0]        opcode       = 3'd0;
	logic [3:0]        target_floor = 4'd0;
	logic [7:0]        rider_id     = 8'd0;
	logic [7:0]        pause_cycles = 8'd0;
	logic              call_on      = 1'b0;
	logic              busy;
	logic              result_strobe;
	logic [3:0]        car_floor_out;
	logic signed [1:0] heading;
	logic [7:0]        delay_left;
	logic [3:0]        riders_aboard;
	logic              idle_flag;
	logic              stop_here;
	logic              requests_ahead;
	logic              leaving_valid;
	logic [7:0]        leaving_rider;
	logic              last;
	logic              overload;

	// car model
	bit                m_used[CAP] = '{default: 1'b0};
	logic [7:0]        m_rider[CAP];
	logic [3:0]        m_tgt[CAP];
	logic [3:0]        m_floor = '0;
	logic [1:0]        m_head  = HEAD_IDLE;
	logic [7:0]        m_delay = '0;
	int                m_count = 0;
	logic [FLOORS-1:0] m_cabin = '0;
	logic [FLOORS-1:0] m_hall  = '0;

	car_status_t pending_status[$];
	int          mismatches  = 0;
	int          beats_sent  = 0;
	int          gap_pct     = 0;
	int          quiet_cycles = 0;

	elevator_car_controller_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.target_floor   (target_floor),
		.rider_id       (rider_id),
		.pause_cycles   (pause_cycles),
		.call_on        (call_on),
		.result_strobe  (result_strobe),
		.car_floor_out  (car_floor_out),
		.heading        (heading),
		.delay_left     (delay_left),
		.riders_aboard  (riders_aboard),
		.idle_flag      (idle_flag),
		.stop_here      (stop_here),
		.requests_ahead (requests_ahead),
		.leaving_valid  (leaving_valid),
		.leaving_rider  (leaving_rider),
		.last           (last),
		.overload       (overload)
	);

	always #5 clk = ~clk;

	function automatic car_status_t car_status(logic lv, logic [7:0] lrider, logic lst,
			logic ovl);
		car_status_t s;
		logic [FLOORS-1:0] req;
		int f;
		req = m_cabin | m_hall;
		s.floor_no = m_floor;
		s.head = m_head;
		s.delay = m_delay;
		s.riders = m_count[3:0];
		s.idle = (req == '0);
		s.stop = m_cabin[m_floor];
		s.ahead = 1'b0;
		for (f = 0; f < FLOORS; f++) begin
			if (req[f] && ((m_head == HEAD_UP && f > m_floor) ||
					(m_head == HEAD_DOWN && f < m_floor)))
				s.ahead = 1'b1;
		end
		s.lv = lv;
		s.lrider = lrider;
		s.lst = lst;
		s.ovl = ovl;
		return s;
	endfunction

	// advance the car model by one accepted beat and queue its results
	task automatic model_step(op_t op, logic [3:0] tgt_in, logic [7:0] rid, logic [7:0] pc,
			logic con);
		logic [3:0] t;
		logic [7:0] ids[CAP];
		int n;
		int i;
		int k;
		logic up;
		logic down;
		logic ovl;
		bit placed;
		car_status_t s;
		t = (tgt_in >= FLOORS) ? 4'(FLOORS - 1) : tgt_in;
		n = 0;
		ovl = 1'b0;
		up = 1'b0;
		down = 1'b0;
		placed = 1'b0;
		case (op)
			OP_TICK: begin
				if (m_delay != 0)
					m_delay--;
				else if (m_head == HEAD_UP) begin
					if (m_floor < FLOORS - 1) m_floor++;
				end else if (m_head == HEAD_DOWN) begin
					if (m_floor > 0) m_floor--;
				end
			end
			OP_PAUSE: m_delay = pc;
			OP_BOARD: begin
				if (m_count >= CAP)
					ovl = 1'b1;
				else begin
					for (i = 0; i < CAP; i++) begin
						if (!m_used[i] && !placed) begin
							m_used[i] = 1'b1;
							m_rider[i] = rid;
							m_tgt[i] = t;
							m_count++;
							placed = 1'b1;
						end
					end
				end
			end
			OP_UNLOAD: begin
				for (i = 0; i < CAP; i++) begin
					if (m_used[i] && m_tgt[i] == m_floor) begin
						ids[n] = m_rider[i];
						n++;
						m_used[i] = 1'b0;
						if (m_count > 0) m_count--;
					end
				end
			end
			OP_CHOOSE: begin
				for (i = 0; i < CAP; i++) begin
					if (m_used[i]) begin
						if (m_tgt[i] > m_floor) up = 1'b1;
						else if (m_tgt[i] < m_floor) down = 1'b1;
					end
				end
				if (m_head == HEAD_IDLE) begin
					if (up) m_head = HEAD_UP;
					else if (down) m_head = HEAD_DOWN;
				end else if (m_head == HEAD_UP) begin
					m_head = up ? HEAD_UP : (down ? HEAD_DOWN : HEAD_IDLE);
				end else begin
					m_head = down ? HEAD_DOWN : (up ? HEAD_UP : HEAD_IDLE);
				end
			end
			OP_REBUILD: begin
				m_cabin = '0;
				for (i = 0; i < CAP; i++)
					if (m_used[i]) m_cabin[m_tgt[i]] = 1'b1;
			end
			OP_HALL: m_hall[t] = con;
			default: ;
		endcase
		if (n > 0) begin
			// every leaving rider gets a beat of its own, carrying the status after all left
			for (k = 0; k < n; k++) begin
				s = car_status(1'b1, ids[k], k == n - 1, 1'b0);
				pending_status.push_back(s);
			end
		end else begin
			s = car_status(1'b0, 8'd0, 1'b1, ovl);
			pending_status.push_back(s);
		end
	endtask

	task automatic send_beat(op_t op, logic [3:0] tgt, logic [7:0] rid, logic [7:0] pc,
			logic con);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		target_floor <= tgt;
		rider_id <= rid;
		pause_cycles <= pc;
		call_on <= con;
		do @(posedge clk); while (busy !== 1'b0);
		model_step(op, tgt, rid, pc, con);
		beats_sent++;
	endtask

	function automatic void check_field(string name, logic [7:0] exp, logic [7:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		car_status_t e;
		if (arst_n && result_strobe) begin
			if (pending_status.size() == 0) begin
				$error("result beat with nothing pending");
				mismatches++;
			end else begin
				e = pending_status.pop_front();
				check_field("car_floor_out", 8'(e.floor_no), 8'(car_floor_out));
				check_field("heading", 8'(e.head), 8'($unsigned(heading)));
				check_field("delay_left", e.delay, delay_left);
				check_field("riders_aboard", 8'(e.riders), 8'(riders_aboard));
				check_field("idle_flag", 8'(e.idle), 8'(idle_flag));
				check_field("stop_here", 8'(e.stop), 8'(stop_here));
				check_field("requests_ahead", 8'(e.ahead), 8'(requests_ahead));
				check_field("leaving_valid", 8'(e.lv), 8'(leaving_valid));
				check_field("leaving_rider", e.lrider, leaving_rider);
				check_field("last", 8'(e.lst), 8'(last));
				check_field("overload", 8'(e.ovl), 8'(overload));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// unused opcode with every field bit set, then unload on an empty car
	task automatic test_idle_status();
		send_beat(OP_NOP, 4'hF, 8'hFF, 8'hFF, 1'b1);
		send_beat(OP_UNLOAD, 4'h0, 8'h00, 8'h00, 1'b0);
	endtask

	task automatic test_boarding_overload();
		send_beat(OP_BOARD, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_BOARD, 4'd15, 8'hFF, 8'hFF, 1'b1);
		send_beat(OP_BOARD, 4'd0, 8'h5A, 8'h00, 1'b0);
		send_beat(OP_BOARD, 4'd7, 8'hA5, 8'h00, 1'b0);
		send_beat(OP_BOARD, 4'd0, 8'h01, 8'h00, 1'b0);
		send_beat(OP_BOARD, 4'd15, 8'h80, 8'h00, 1'b0);
		send_beat(OP_BOARD, 4'd3, 8'h7F, 8'h00, 1'b0);
		send_beat(OP_BOARD, 4'd8, 8'hFE, 8'h00, 1'b0);
		// car is full now
		send_beat(OP_BOARD, 4'd15, 8'h33, 8'h00, 1'b0);
	endtask

	task automatic test_unload();
		send_beat(OP_REBUILD, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_UNLOAD, 4'd0, 8'h00, 8'h00, 1'b0);
	endtask

	task automatic test_hall_calls();
		send_beat(OP_HALL, 4'd15, 8'h00, 8'h00, 1'b1);
		send_beat(OP_HALL, 4'd0, 8'h00, 8'h00, 1'b1);
		send_beat(OP_HALL, 4'd0, 8'h00, 8'h00, 1'b0);
	endtask

	task automatic test_direction_and_motion();
		send_beat(OP_CHOOSE, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_PAUSE, 4'd0, 8'h00, 8'hFF, 1'b0);
		send_beat(OP_TICK, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_PAUSE, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_TICK, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_TICK, 4'd0, 8'h00, 8'h00, 1'b0);
		send_beat(OP_HALL, 4'd15, 8'h00, 8'h00, 1'b0);
	endtask

	// random opcodes and fields, long door delays now and then
	task automatic noise_burst();
		logic [7:0] pc;
		repeat ($urandom_range(1, 4)) begin
			pc = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
			send_beat(op_t'($urandom_range(7)), 4'($urandom_range(15)),
				8'($urandom_range(255)), pc, 1'($urandom_range(1)));
		end
	endtask

	// board a few riders, pick a heading, ride to the nearest stop and unload
	task automatic trip_leg();
		int f;
		int i;
		int span;
		int ticks;
		logic [3:0] t;
		if ($urandom_range(3) == 0)
			send_beat(OP_HALL, 4'($urandom_range(15)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 1'($urandom_range(1)));
		repeat ($urandom_range(3)) begin
			if ($urandom_range(3) == 0)
				t = 4'($urandom_range(15));
			else begin
				f = int'(m_floor) + int'($urandom_range(8)) - 4;
				t = (f < 0) ? 4'd0 : ((f > FLOORS - 1) ? 4'(FLOORS - 1) : 4'(f));
			end
			send_beat(OP_BOARD, t, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
		end
		send_beat(OP_REBUILD, 4'($urandom_range(15)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 1'($urandom_range(1)));
		send_beat(OP_CHOOSE, 4'($urandom_range(15)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 1'($urandom_range(1)));
		if (m_head != HEAD_IDLE) begin
			span = FLOORS;
			for (i = 0; i < CAP; i++) begin
				if (m_used[i] && m_head == HEAD_UP && m_tgt[i] > m_floor &&
						int'(m_tgt[i] - m_floor) < span)
					span = int'(m_tgt[i] - m_floor);
				if (m_used[i] && m_head == HEAD_DOWN && m_tgt[i] < m_floor &&
						int'(m_floor - m_tgt[i]) < span)
					span = int'(m_floor - m_tgt[i]);
			end
			if (span == FLOORS) span = 1;
			if (m_delay > 6)
				send_beat(OP_PAUSE, 4'($urandom_range(15)), 8'($urandom_range(255)),
					8'($urandom_range(6)), 1'($urandom_range(1)));
			ticks = int'(m_delay) + span;
			// sometimes overshoot toward the end of the shaft, sometimes stop short
			case ($urandom_range(7))
				0: ticks += $urandom_range(1, 16);
				1: if (ticks > 0) ticks--;
				default: ;
			endcase
			repeat (ticks)
				send_beat(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 1'($urandom_range(1)));
		end
		send_beat(OP_UNLOAD, 4'($urandom_range(15)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic test_random_traffic(int pct, int beats);
		int stop_at;
		gap_pct = pct;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(4) == 0)
				noise_burst();
			else
				trip_leg();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_status();
		test_boarding_overload();
		test_unload();
		test_hall_calls();
		test_direction_and_motion();
		test_random_traffic(0, 100);
		test_random_traffic(80, 100);
		test_random_traffic(0, 100);
		test_random_traffic(36, 100);
		start <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
